@@ hw/rtl/sacl_pkg.sv @@
// Shared types and codes for the set-associative LRU cache tag store.
// No dependencies; imported by the top level, sacl_update and sacl_stats.
package sacl_pkg;

    // Access kinds; the unused code behaves as a load.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int CNT_W      = 32;

    typedef enum logic [2:0] {
        OC_HIT            = 3'd0,
        OC_MISS           = 3'd1,
        OC_MISS_EVICT     = 3'd2,
        OC_MISS_HIT       = 3'd3,
        OC_MISS_EVICT_HIT = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] address;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       outcome;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_out_word;

    // Lookup result handed from the update logic to the counters
    typedef struct packed {
        t_outcome   outcome;
        logic [1:0] hit_inc;
        logic       miss_inc;
        logic       evict_inc;
    } t_upd_res;

endpackage

@@ hw/rtl/set_assoc_cache_lru_sim_unit.sv @@
// Top level of the set-associative cache tag store with LRU replacement.
// Depends on sacl_pkg, sacl_tag_mem, sacl_update and sacl_stats.
//
//   Port group      Dir   Handshake              Word
//   i_in_*          in    valid / ready          t_in_word  {operation, address}
//   o_out_*         out   valid / ready          t_out_word {outcome, totals}
//   i_cfg_*         in    write enable, no wait  index + 6-bit data
//
// For each word the accept edge issues the set row read; the lookup state that
// follows compares tags, picks the way and writes the row back.
// After reset a clearing pass zeroes one set row a cycle, all 2**MAX_SET_BITS
// rows; no word is accepted until it ends. Config writes still land.
// A new word is taken while a result waits in the output register; the
// lookup cycle holds (read data kept) until that register is free.
// One word in flight at a time, so no read can see a stale row.
module set_assoc_cache_lru_sim_unit
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W    = $clog2(MAX_WAYS + 1);
    localparam int TAG_W     = ADDR_WIDTH;
    localparam int ROW_W     = MAX_WAYS * (1 + TAG_W + RANK_W);

    // configuration, held already clamped to usable values
    logic [2:0]        r_sb;
    logic [5:0]        r_block;
    logic [RANK_W-1:0] r_ways;

    t_state r_state, n_state;
    logic [SET_IDX_W-1:0] r_clr_idx;
    logic [SET_IDX_W-1:0] r_set;
    logic [TAG_W-1:0]     r_tag;
    logic                 r_modify;
    logic                 r_o_valid;
    t_out_word            r_o_word;

    logic                 accept;
    logic                 can_load;
    logic                 load_res;
    logic [TAG_W-1:0]     in_addr;
    logic [TAG_W-1:0]     addr_shr;
    logic [SET_IDX_W-1:0] set_mask;
    logic [SET_IDX_W-1:0] in_set;
    logic [TAG_W-1:0]     in_tag;
    logic                 mem_we;
    logic [SET_IDX_W-1:0] mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     upd_row;
    t_upd_res             upd_res;
    logic [CNT_W-1:0]     hit_next;
    logic [CNT_W-1:0]     miss_next;
    logic [CNT_W-1:0]     evict_next;
    logic [4:0]           ways_wr;

    // ---- configuration writes ----
    assign ways_wr = {1'b0, i_cfg_wdata[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb    <= '0;
            r_block <= '0;
            r_ways  <= RANK_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SET_BITS: begin
                    r_sb <= ({1'b0, i_cfg_wdata[2:0]} > 4'(MAX_SET_BITS))
                          ? 3'(MAX_SET_BITS) : i_cfg_wdata[2:0];
                end
                CFG_BLOCK_BITS: begin
                    r_block <= i_cfg_wdata;
                end
                CFG_WAYS: begin
                    if (ways_wr == 5'd0) begin
                        r_ways <= RANK_W'(1);
                    end else if (ways_wr > 5'(MAX_WAYS)) begin
                        r_ways <= RANK_W'(MAX_WAYS);
                    end else begin
                        r_ways <= RANK_W'(ways_wr);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---- address split: set above the block offset, tag above the set ----
    assign in_addr  = i_in_word.address[ADDR_WIDTH-1:0];
    assign addr_shr = in_addr >> r_block;
    assign set_mask = ~({SET_IDX_W{1'b1}} << r_sb);
    assign in_set   = addr_shr[SET_IDX_W-1:0] & set_mask;
    assign in_tag   = in_addr >> (7'(r_block) + 7'(r_sb));

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign can_load   = !r_o_valid || i_out_ready;

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_IDX_W'(1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_wdata = upd_row;
        load_res  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                if (r_clr_idx == SET_IDX_W'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // write back and release the word only once the result can go out
                if (can_load) begin
                    mem_we   = 1'b1;
                    load_res = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // per-word payload captured at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set    <= in_set;
            r_tag    <= in_tag;
            r_modify <= (i_in_word.operation == OP_MODIFY);
        end
    end

    sacl_tag_mem #(
        .DEPTH (NUM_SETS),
        .IDX_W (SET_IDX_W),
        .ROW_W (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (rd_row)
    );

    sacl_update #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W)
    ) u_upd (
        .i_row    (rd_row),
        .i_tag    (r_tag),
        .i_ways   (r_ways),
        .i_modify (r_modify),
        .o_row    (upd_row),
        .o_res    (upd_res)
    );

    sacl_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (load_res),
        .i_res        (upd_res),
        .o_hit_next   (hit_next),
        .o_miss_next  (miss_next),
        .o_evict_next (evict_next)
    );

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_res) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_o_word.outcome        <= upd_res.outcome;
            r_o_word.hit_total      <= hit_next;
            r_o_word.miss_total     <= miss_next;
            r_o_word.eviction_total <= evict_next;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

endmodule

@@ hw/rtl/sacl_tag_mem.sv @@
// One-row-per-set tag/valid/rank store: one write port, one read port,
// registered read data. Depends on nothing.
module sacl_tag_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int ROW_W = 616
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [ROW_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [ROW_W-1:0] o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sacl_update.sv @@
// Hit search, victim choice and LRU rank update for one set row.
// Depends on sacl_pkg.
module sacl_update
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int TAG_W    = 64,
    parameter int RANK_W   = 4
) (
    input  logic [MAX_WAYS*(1+TAG_W+RANK_W)-1:0] i_row,
    input  logic [TAG_W-1:0]                     i_tag,
    input  logic [RANK_W-1:0]                    i_ways,
    input  logic                                 i_modify,
    output logic [MAX_WAYS*(1+TAG_W+RANK_W)-1:0] o_row,
    output t_upd_res                             o_res
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0]              v;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   t;
    logic [MAX_WAYS-1:0][RANK_W-1:0]  rk;
    logic [MAX_WAYS-1:0]              upd_v;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   upd_t;
    logic [MAX_WAYS-1:0][RANK_W-1:0]  upd_rk;

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    lru_way;
    logic [WAY_W-1:0]    sel_way;
    logic                hit;
    logic                has_free;
    logic [RANK_W-1:0]   old_rank;

    assign {rk, t, v} = i_row;
    assign o_row      = {upd_rk, upd_t, upd_v};

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i]   = RANK_W'(i) < i_ways;
            hit_vec[i]  = in_use[i] && v[i] && (t[i] == i_tag);
            free_vec[i] = in_use[i] && !v[i];
        end
        hit      = |hit_vec;
        has_free = |free_vec;

        // lowest-numbered match / free way
        hit_way  = '0;
        free_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_way = WAY_W'(i);
            end
            if (free_vec[i]) begin
                free_way = WAY_W'(i);
            end
        end

        // smallest rank, lowest way wins a tie
        lru_way = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && (rk[i] < rk[lru_way])) begin
                lru_way = WAY_W'(i);
            end
        end

        if (hit) begin
            sel_way = hit_way;
        end else if (has_free) begin
            sel_way = free_way;
        end else begin
            sel_way = lru_way;
        end
        old_rank = rk[sel_way];

        upd_v = v;
        upd_t = t;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_W'(i) == sel_way) begin
                upd_rk[i] = i_ways;
            end else if (in_use[i] && v[i] && (rk[i] > old_rank)) begin
                upd_rk[i] = rk[i] - RANK_W'(1);
            end else begin
                upd_rk[i] = rk[i];
            end
        end
        upd_v[sel_way] = 1'b1;
        upd_t[sel_way] = i_tag;

        o_res.miss_inc  = !hit;
        o_res.evict_inc = !hit && !has_free;
        if (hit) begin
            o_res.outcome = OC_HIT;
            o_res.hit_inc = i_modify ? 2'd2 : 2'd1;
        end else begin
            o_res.hit_inc = i_modify ? 2'd1 : 2'd0;
            if (has_free) begin
                o_res.outcome = i_modify ? OC_MISS_HIT : OC_MISS;
            end else begin
                o_res.outcome = i_modify ? OC_MISS_EVICT_HIT : OC_MISS_EVICT;
            end
        end
    end

endmodule

@@ hw/rtl/sacl_stats.sv @@
// Saturating hit, miss and eviction totals.
// Depends on sacl_pkg; next totals are shown combinationally for the result word.
module sacl_stats
    import sacl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_upd_res         i_res,
    output logic [CNT_W-1:0] o_hit_next,
    output logic [CNT_W-1:0] o_miss_next,
    output logic [CNT_W-1:0] o_evict_next
);

    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evictions;
    logic [CNT_W:0]   hit_sum;
    logic [CNT_W:0]   miss_sum;
    logic [CNT_W:0]   evict_sum;

    always_comb begin
        hit_sum   = {1'b0, r_hits} + (CNT_W+1)'(i_res.hit_inc);
        miss_sum  = {1'b0, r_misses} + (CNT_W+1)'(i_res.miss_inc);
        evict_sum = {1'b0, r_evictions} + (CNT_W+1)'(i_res.evict_inc);
        o_hit_next   = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
        o_miss_next  = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
        o_evict_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_misses    <= '0;
            r_evictions <= '0;
        end else if (i_en) begin
            r_hits      <= o_hit_next;
            r_misses    <= o_miss_next;
            r_evictions <= o_evict_next;
        end
    end

endmodule
